// ===== sv/scf_pkg.sv =====
// ----------------------------------------------------------------------------
// scf_pkg
// Shared types, constants and command patterns for the serial command line
// framer.
// ----------------------------------------------------------------------------
package scf_pkg;

	// Line store geometry. The capacity must stay within 8 to 255.
	localparam int LINE_CAPACITY = 128;
	localparam int ADDR_W        = $clog2(LINE_CAPACITY);
	localparam int POS_W         = 8;

	localparam logic [15:0] GAP_TICKS_RESET = 16'd2;

	localparam logic [7:0] CHAR_CR = 8'h0d;
	localparam logic [7:0] CHAR_LF = 8'h0a;

	// Smallest line that is latched is one byte longer than this.
	localparam logic [POS_W-1:0] MIN_LINE_LEN = POS_W'(2);

	// Command codes reported on a fetch.
	localparam logic [2:0] CODE_NONE    = 3'd0;
	localparam logic [2:0] CODE_UNKNOWN = 3'd1;
	localparam logic [2:0] CODE_TEM0    = 3'd2;
	localparam logic [2:0] CODE_TEM97   = 3'd3;
	localparam logic [2:0] CODE_ENSOR   = 3'd4;
	localparam logic [2:0] CODE_DISSOR  = 3'd5;
	localparam logic [2:0] CODE_SEND    = 3'd6;

	// Prefix patterns, in priority order, padded with zero past their length.
	localparam int NUM_PAT    = 5;
	localparam int PREFIX_LEN = 6;
	localparam int IDX_W      = $clog2(PREFIX_LEN + 1);

	localparam int PAT_TEM0   = 0;
	localparam int PAT_TEM97  = 1;
	localparam int PAT_ENSOR  = 2;
	localparam int PAT_DISSOR = 3;
	localparam int PAT_SEND   = 4;

	localparam logic [7:0] PAT_CHARS [NUM_PAT][PREFIX_LEN] = '{
		'{8'h54, 8'h45, 8'h4d, 8'h3d, 8'h30, 8'h00},  // TEM=0
		'{8'h54, 8'h45, 8'h4d, 8'h3d, 8'h39, 8'h37},  // TEM=97
		'{8'h45, 8'h4e, 8'h53, 8'h4f, 8'h52, 8'h00},  // ENSOR
		'{8'h44, 8'h49, 8'h53, 8'h53, 8'h4f, 8'h52},  // DISSOR
		'{8'h53, 8'h45, 8'h4e, 8'h44, 8'h00, 8'h00}   // SEND
	};

	localparam logic [IDX_W-1:0] PAT_LEN [NUM_PAT] = '{
		IDX_W'(5), IDX_W'(6), IDX_W'(5), IDX_W'(6), IDX_W'(4)
	};

	typedef struct packed {
		logic        cmd;
		logic [7:0]  data_byte;
		logic [15:0] arrival_time;
	} scf_in_item_t;

	typedef struct packed {
		logic             byte_stored;
		logic             line_done;
		logic [2:0]       command_code;
		logic [POS_W-1:0] line_length;
	} scf_out_item_t;

	// Status from the classifier back to the framer.
	typedef struct packed {
		logic       busy;
		logic       done;
		logic [2:0] code;
	} scf_cls_rsp_t;

endpackage

// ===== sv/scf_ram.sv =====
// ----------------------------------------------------------------------------
// scf_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module scf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

// ===== sv/scf_classifier.sv =====
// ----------------------------------------------------------------------------
// scf_classifier
// Reads the first bytes of the line store one per cycle and matches them
// against the command prefixes.
// ----------------------------------------------------------------------------
module scf_classifier import scf_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              rd_en,
	output logic [ADDR_W-1:0] rd_addr,
	input  logic [7:0]        rd_data,
	output scf_cls_rsp_t      rsp
);

	logic                 busy_q;
	logic [IDX_W-1:0]     issue_idx_q;
	logic                 cmp_valid_s1;
	logic [IDX_W-1:0]     cmp_idx_s1;
	logic [NUM_PAT-1:0]   match_q;
	logic [NUM_PAT-1:0]   match_d;
	logic                 last_cmp;

	assign rd_en   = busy_q && (issue_idx_q < IDX_W'(PREFIX_LEN));
	assign rd_addr = ADDR_W'(issue_idx_q);

	// A character past a pattern's length does not take part in its match.
	always_comb begin
		match_d = match_q;
		if (cmp_valid_s1) begin
			for (int p = 0; p < NUM_PAT; p++) begin
				if (cmp_idx_s1 < PAT_LEN[p] && rd_data != PAT_CHARS[p][cmp_idx_s1]) begin
					match_d[p] = 1'b0;
				end
			end
		end
	end

	assign last_cmp = cmp_valid_s1 && (cmp_idx_s1 == IDX_W'(PREFIX_LEN - 1));

	always_comb begin
		rsp.busy = busy_q;
		rsp.done = last_cmp;
		if (match_d[PAT_TEM0]) begin
			rsp.code = CODE_TEM0;
		end else if (match_d[PAT_TEM97]) begin
			rsp.code = CODE_TEM97;
		end else if (match_d[PAT_ENSOR]) begin
			rsp.code = CODE_ENSOR;
		end else if (match_d[PAT_DISSOR]) begin
			rsp.code = CODE_DISSOR;
		end else if (match_d[PAT_SEND]) begin
			rsp.code = CODE_SEND;
		end else begin
			rsp.code = CODE_UNKNOWN;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			issue_idx_q  <= '0;
			cmp_valid_s1 <= 1'b0;
			cmp_idx_s1   <= '0;
			match_q      <= '1;
		end else begin
			cmp_valid_s1 <= rd_en;
			cmp_idx_s1   <= issue_idx_q;
			if (start) begin
				busy_q      <= 1'b1;
				issue_idx_q <= '0;
				match_q     <= '1;
			end else begin
				match_q <= match_d;
				if (rd_en) begin
					issue_idx_q <= issue_idx_q + IDX_W'(1);
				end
				if (last_cmp) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

endmodule

// ===== sv/serial_command_line_framer.sv =====
// ----------------------------------------------------------------------------
// serial_command_line_framer
// Frames serial bytes into CR LF terminated lines and classifies a pending
// line by its command prefix on request.
// ----------------------------------------------------------------------------
// The input channel carries items of two kinds. A byte item (cmd low) brings
// a received byte and its arrival tick; a fetch item (cmd high) asks for the
// pending line to be classified and released. Every input item yields exactly
// one output item, in order.
// A byte item is handled in the cycle it is accepted: the line store write,
// the gap check and the end-of-line check all happen at that edge, which also
// registers the result in the output or skid register. Byte items can follow
// each other in every cycle while the skid register is free.
// A fetch with no line pending answers the same way. A fetch of a pending
// line reads the first six store entries through the single RAM read port,
// one per cycle, and compares each against all patterns; its result is
// registered once the last entry is compared, and the input is held off
// during that read sequence. Nothing is written to the store then, so reads
// and writes never touch the same entry at once.
// The output side has a result register and a skid register, so an item is
// still accepted while one result waits for the receiver. When both are
// full, in_ready drops until the receiver takes a result.
// Reset clears the framing state, the pending line and the output valid
// flags and restores gap_ticks to two; the line store itself is not cleared.
// ----------------------------------------------------------------------------
module serial_command_line_framer import scf_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  scf_in_item_t  in_item,
	output logic          out_valid,
	input  logic          out_ready,
	output scf_out_item_t out_item,
	input  logic          cfg_wr_en,
	input  logic [15:0]   cfg_wr_data
);

	// Configuration and framing state.
	logic [15:0]      gap_ticks_q;
	logic [POS_W-1:0] wr_pos_q;
	logic [7:0]       prev_byte_q;
	logic [15:0]      last_arrival_q;
	logic [POS_W-1:0] pending_len_q;

	// Output result register and skid register.
	logic          out_valid_q;
	scf_out_item_t out_q;
	logic          skid_valid_q;
	scf_out_item_t skid_q;

	logic          in_fire;
	logic          byte_fire;
	logic          fetch_fire;
	logic          cls_start;
	scf_cls_rsp_t  cls_rsp;
	logic          cls_rd_en;
	logic [ADDR_W-1:0] cls_rd_addr;
	logic [7:0]    cls_rd_data;

	logic [15:0]      gap;
	logic [POS_W-1:0] pos_start;
	logic [POS_W-1:0] pos_after;
	logic [POS_W-1:0] wr_pos_d;
	logic [POS_W-1:0] pending_len_d;
	logic             store_byte;
	logic             end_of_line;
	logic             line_latched;

	logic          res_push;
	scf_out_item_t res;
	logic          out_pop;

	// No new item while the classifier owns the store or the skid is taken.
	assign in_ready   = !skid_valid_q && !cls_rsp.busy;
	assign in_fire    = in_valid && in_ready;
	assign byte_fire  = in_fire && !in_item.cmd;
	assign fetch_fire = in_fire && in_item.cmd;
	assign cls_start  = fetch_fire && (pending_len_q != '0);

	// Wrapping gap since the previous byte; a long gap restarts the line.
	assign gap       = in_item.arrival_time - last_arrival_q;
	assign pos_start = (gap > gap_ticks_q) ? '0 : wr_pos_q;

	assign end_of_line = (prev_byte_q == CHAR_CR) && (in_item.data_byte == CHAR_LF);

	// While a line is pending, bytes only move the time stamp and the
	// restart; nothing is stored and the previous byte is kept.
	always_comb begin
		store_byte    = 1'b0;
		line_latched  = 1'b0;
		pos_after     = pos_start;
		wr_pos_d      = pos_start;
		pending_len_d = pending_len_q;
		if (pending_len_q == '0) begin
			store_byte = pos_start < POS_W'(LINE_CAPACITY);
			if (store_byte) begin
				pos_after = pos_start + POS_W'(1);
			end
			wr_pos_d = pos_after;
			if (end_of_line) begin
				wr_pos_d = '0;
				if (pos_after > MIN_LINE_LEN) begin
					line_latched  = 1'b1;
					pending_len_d = pos_after;
				end
			end
		end
	end

	scf_ram #(
		.WIDTH(8),
		.DEPTH(LINE_CAPACITY)
	) u_line_store (
		.clk    (clk),
		.wr_en  (byte_fire && store_byte),
		.wr_addr(pos_start[ADDR_W-1:0]),
		.wr_data(in_item.data_byte),
		.rd_en  (cls_rd_en),
		.rd_addr(cls_rd_addr),
		.rd_data(cls_rd_data)
	);

	scf_classifier u_classifier (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cls_start),
		.rd_en  (cls_rd_en),
		.rd_addr(cls_rd_addr),
		.rd_data(cls_rd_data),
		.rsp    (cls_rsp)
	);

	// One result per item: a byte, an empty fetch, or a finished classification.
	always_comb begin
		res_push = 1'b0;
		res      = '0;
		if (byte_fire) begin
			res_push         = 1'b1;
			res.byte_stored  = store_byte;
			res.line_done    = line_latched;
			res.command_code = CODE_NONE;
			res.line_length  = pending_len_d;
		end else if (fetch_fire && !cls_start) begin
			res_push         = 1'b1;
			res.command_code = CODE_NONE;
		end else if (cls_rsp.done) begin
			res_push         = 1'b1;
			res.command_code = cls_rsp.code;
			res.line_length  = pending_len_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gap_ticks_q    <= GAP_TICKS_RESET;
			wr_pos_q       <= '0;
			prev_byte_q    <= '0;
			last_arrival_q <= '0;
			pending_len_q  <= '0;
		end else begin
			if (cfg_wr_en) begin
				gap_ticks_q <= cfg_wr_data;
			end
			if (byte_fire) begin
				last_arrival_q <= in_item.arrival_time;
				wr_pos_q       <= wr_pos_d;
				pending_len_q  <= pending_len_d;
				if (pending_len_q == '0) begin
					prev_byte_q <= in_item.data_byte;
				end
			end
			if (cls_rsp.done) begin
				pending_len_q <= '0;
			end
		end
	end

	// Two-entry output buffer: the skid only fills when the result register
	// is held by the receiver.
	assign out_pop = out_valid_q && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else begin
			if (!out_valid_q || out_pop) begin
				out_valid_q <= skid_valid_q || res_push;
				if (skid_valid_q) begin
					skid_valid_q <= res_push;
				end
			end else if (res_push) begin
				skid_valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (!out_valid_q || out_pop) begin
			if (skid_valid_q) begin
				out_q  <= skid_q;
				skid_q <= res;
			end else begin
				out_q <= res;
			end
		end else if (res_push) begin
			skid_q <= res;
		end
	end

	assign out_valid = out_valid_q;
	assign out_item  = out_q;

endmodule

// ===== sv/scf_checker.sv =====
// ----------------------------------------------------------------------------
// scf_checker
// Port-level checks for the serial command line framer, bound to the top.
// ----------------------------------------------------------------------------
module scf_checker import scf_pkg::*; (
	input logic          clk,
	input logic          arst_n,
	input logic          out_valid,
	input logic          out_ready,
	input scf_out_item_t out_item
);

	// A stalled result stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_item))
		else $error("output item changed while stalled");

	// A classification result never carries byte flags.
	a_fetch_no_flags: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command_code != CODE_NONE |->
			!out_item.byte_stored && !out_item.line_done)
		else $error("fetch result carries byte flags");

	// A completed line is longer than the minimum and fits the store.
	a_done_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.line_done |->
			out_item.line_length > MIN_LINE_LEN &&
			out_item.line_length <= POS_W'(LINE_CAPACITY))
		else $error("completed line has bad length");

	// A classified line always reports its length.
	a_code_length: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_item.command_code != CODE_NONE |->
			out_item.line_length > MIN_LINE_LEN)
		else $error("classified line without length");

endmodule

bind serial_command_line_framer scf_checker u_scf_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.out_valid(out_valid),
	.out_ready(out_ready),
	.out_item (out_item)
);

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the serial command line framer: a short directed
// run, then several randomized phases at different gap settings and
// handshake pressures, with every output item checked against a local model.
// ----------------------------------------------------------------------------
import scf_pkg::*;

class framer_scoreboard;
	logic [7:0]    line_buf [LINE_CAPACITY];
	int unsigned   fill_pos;
	logic [7:0]    last_byte;
	logic [15:0]   last_tick;
	int unsigned   held_len;
	logic [15:0]   gap_limit;
	scf_out_item_t awaited_outputs [$];
	int unsigned   mismatches;

	function new();
		foreach (line_buf[i])
			line_buf[i] = 8'h00;
		fill_pos   = 0;
		last_byte  = 8'h00;
		last_tick  = 16'h0000;
		held_len   = 0;
		gap_limit  = GAP_TICKS_RESET;
		mismatches = 0;
	endfunction

	function void set_gap(logic [15:0] value);
		gap_limit = value;
	endfunction

	function void report(string what);
		$display("[%0t] %s", $time, what);
		mismatches++;
	endfunction

	function bit starts_with(string pat);
		for (int i = 0; i < pat.len(); i++) begin
			if (line_buf[i] !== pat[i])
				return 1'b0;
		end
		return 1'b1;
	endfunction

	// Framing and classification of one input item.
	function scf_out_item_t predict_framer(scf_in_item_t it);
		scf_out_item_t res;
		logic [15:0]   gap;
		res = '0;
		if (!it.cmd) begin
			gap = it.arrival_time - last_tick;
			if (gap > gap_limit)
				fill_pos = 0;
			last_tick = it.arrival_time;
			if (held_len == 0) begin
				if (fill_pos < LINE_CAPACITY) begin
					line_buf[fill_pos] = it.data_byte;
					fill_pos++;
					res.byte_stored = 1'b1;
				end
				if (last_byte == CHAR_CR && it.data_byte == CHAR_LF) begin
					if (fill_pos > MIN_LINE_LEN) begin
						held_len = fill_pos;
						res.line_done = 1'b1;
					end
					fill_pos = 0;
				end
				last_byte = it.data_byte;
			end
			res.line_length = POS_W'(held_len);
		end else if (held_len != 0) begin
			if (starts_with("TEM=0"))
				res.command_code = CODE_TEM0;
			else if (starts_with("TEM=97"))
				res.command_code = CODE_TEM97;
			else if (starts_with("ENSOR"))
				res.command_code = CODE_ENSOR;
			else if (starts_with("DISSOR"))
				res.command_code = CODE_DISSOR;
			else if (starts_with("SEND"))
				res.command_code = CODE_SEND;
			else
				res.command_code = CODE_UNKNOWN;
			res.line_length = POS_W'(held_len);
			held_len = 0;
		end
		return res;
	endfunction

	function void note_input(scf_in_item_t it);
		awaited_outputs.push_back(predict_framer(it));
	endfunction

	function void check_output(scf_out_item_t got);
		scf_out_item_t want;
		if (awaited_outputs.size() == 0) begin
			report($sformatf("output item %h arrived with nothing awaited", got));
			return;
		end
		want = awaited_outputs.pop_front();
		if (got.byte_stored !== want.byte_stored)
			report($sformatf("byte_stored %b, want %b", got.byte_stored, want.byte_stored));
		if (got.line_done !== want.line_done)
			report($sformatf("line_done %b, want %b", got.line_done, want.line_done));
		if (got.command_code !== want.command_code)
			report($sformatf("command_code %0d, want %0d",
				got.command_code, want.command_code));
		if (got.line_length !== want.line_length)
			report($sformatf("line_length %0d, want %0d", got.line_length, want.line_length));
	endfunction

	function int unsigned outstanding();
		return awaited_outputs.size();
	endfunction
endclass

module testbench;

	// A stall of this many cycles with no item moving on either channel means
	// the block has hung. The slowest legal step is a fetch of a pending line
	// behind a receiver that stalls about half the time, so this leaves a wide
	// margin.
	localparam int HANG_LIMIT   = 2000;
	// Extra cycles after the last result, well past the fetch latency.
	localparam int DRAIN_CYCLES = 16;
	// Input items queued for each random phase.
	localparam int PHASE_ITEMS  = 135;

	logic          clk         = 1'b0;
	logic          arst_n      = 1'b0;
	logic          in_valid    = 1'b0;
	logic          in_ready;
	scf_in_item_t  in_item     = '0;
	logic          out_valid;
	logic          out_ready   = 1'b0;
	scf_out_item_t out_item;
	logic          cfg_wr_en   = 1'b0;
	logic [15:0]   cfg_wr_data = '0;

	framer_scoreboard sb = new();

	scf_in_item_t stim_q [$];
	logic [15:0]  tick_now   = 16'h0000;
	logic [15:0]  gen_gap    = GAP_TICKS_RESET;
	int unsigned  stall_pct  = 0;
	int unsigned  hang_count = 0;

	serial_command_line_framer u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data)
	);

	always #1 clk = ~clk;

	// Receiver: every item taken at an edge is checked against the oldest
	// expectation, and ready is redrawn for the next edge.
	always @(posedge clk) begin
		if (out_valid && out_ready)
			sb.check_output(out_item);
		out_ready <= ($urandom_range(99) >= stall_pct);
	end

	// Watchdog on cycles in which no item moves.
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			hang_count <= 0;
		else
			hang_count <= hang_count + 1;
		if (hang_count >= HANG_LIMIT) begin
			$display("serial_command_line_framer: mismatch");
			$finish;
		end
	end

	// Tick step to the next byte. Mostly within the allowed gap, often right
	// at it; where a break is allowed, sometimes one past it or anything.
	function automatic logic [15:0] pick_delta(bit may_break);
		int unsigned r;
		r = $urandom_range(99);
		if (may_break && r < 5 && gen_gap != 16'hffff)
			return gen_gap + 16'd1;
		if (may_break && r < 8)
			return 16'($urandom);
		if (r < 20)
			return gen_gap;
		return 16'($urandom_range(0, (gen_gap < 4) ? gen_gap : 4));
	endfunction

	function automatic void push_at(logic [7:0] b, logic [15:0] t);
		scf_in_item_t it;
		tick_now        = t;
		it.cmd          = 1'b0;
		it.data_byte    = b;
		it.arrival_time = t;
		stim_q.push_back(it);
	endfunction

	function automatic void push_byte(logic [7:0] b, bit may_break);
		push_at(b, tick_now + pick_delta(may_break));
	endfunction

	// The byte and tick fields of a fetch are don't-care, so they are random.
	function automatic void push_fetch();
		scf_in_item_t it;
		it.cmd          = 1'b1;
		it.data_byte    = 8'($urandom);
		it.arrival_time = 16'($urandom);
		stim_q.push_back(it);
	endfunction

	function automatic logic [7:0] noise_byte();
		case ($urandom_range(3))
			0: return CHAR_CR;
			1: return CHAR_LF;
			default: return 8'($urandom);
		endcase
	endfunction

	// Line openings: every command, plus near misses that share a prefix.
	function automatic string pick_head();
		case ($urandom_range(10))
			0: return "TEM=0";
			1: return "TEM=97";
			2: return "ENSOR";
			3: return "DISSOR";
			4: return "SEND";
			5: return "TEM=9";
			6: return "DISSO";
			7: return "SEN";
			8: return "ENSO";
			9: return "TEM=";
			default: return "";
		endcase
	endfunction

	// One CR LF terminated line. A few are long enough to overflow the store;
	// the rest are short, some of them too short to be kept.
	function automatic void push_line();
		string       head;
		int unsigned tail_len;
		bit          long_line;
		head      = pick_head();
		long_line = ($urandom_range(99) < 3);
		tail_len  = long_line ? $urandom_range(125, 140) : $urandom_range(0, 6);
		for (int i = 0; i < head.len(); i++)
			push_byte(head[i], $urandom_range(99) < 3);
		for (int i = 0; i < tail_len; i++) begin
			if (long_line)
				push_byte(8'($urandom_range(32, 126)), 1'b0);
			else
				push_byte(8'($urandom), $urandom_range(99) < 3);
		end
		push_byte(CHAR_CR, 1'b0);
		push_byte(CHAR_LF, 1'b0);
	endfunction

	// Mostly whole lines followed by a fetch, with noise bytes, stray fetches
	// and lines sent while another one is still held.
	function automatic void build_phase(int unsigned target);
		int unsigned r;
		while (stim_q.size() < target) begin
			r = $urandom_range(99);
			if (r < 75) begin
				push_line();
				r = $urandom_range(99);
				if (r < 65)
					push_fetch();
				else if (r < 80) begin
					repeat ($urandom_range(1, 3))
						push_byte(noise_byte(), 1'b1);
					push_fetch();
				end
			end else if (r < 92) begin
				repeat ($urandom_range(1, 4))
					push_byte(noise_byte(), 1'b1);
			end else
				push_fetch();
		end
	endfunction

	// Sender: presents queued items, idling between them at the given rate.
	// The local holding flag mirrors in_valid, so an item is noted exactly at
	// the edge where the block takes it.
	task automatic play_items(int unsigned idle_pct);
		bit holding;
		holding = 1'b0;
		while (stim_q.size() > 0 || holding) begin
			@(posedge clk);
			if (holding && in_ready) begin
				sb.note_input(in_item);
				holding = 1'b0;
			end
			if (!holding) begin
				if (stim_q.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_item  <= stim_q.pop_front();
					in_valid <= 1'b1;
					holding  = 1'b1;
				end else
					in_valid <= 1'b0;
			end
		end
	endtask

	task automatic drain_outputs();
		while (sb.outstanding() != 0)
			@(posedge clk);
	endtask

	// Every input item yields a result, so once all results are in, the block
	// is idle and the register may be written.
	task automatic write_gap(logic [15:0] value);
		@(posedge clk);
		cfg_wr_en   <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		sb.set_gap(value);
		gen_gap = value;
	endtask

	task automatic run_phase(logic [15:0] gap, int unsigned send_idle, int unsigned recv_stall);
		write_gap(gap);
		stall_pct = recv_stall;
		build_phase(PHASE_ITEMS);
		play_items(send_idle);
		drain_outputs();
	endtask

	initial begin
		repeat (7)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset gap of two ticks. The first line fills
		// the first seven store entries, so every later fetch reads written
		// entries only.
		push_at("T", 16'd1);
		push_at("E", 16'd2);
		push_at("M", 16'd3);
		push_at("=", 16'd4);
		push_at("0", 16'd5);
		push_at(CHAR_CR, 16'd6);
		push_at(CHAR_LF, 16'd7);
		// Bytes while the line is held are ignored; the first comes after a
		// large gap, the second wraps the tick counter and lands exactly on
		// the allowed gap.
		push_at(8'hff, 16'hffff);
		push_at(8'h00, 16'h0001);
		push_fetch();
		// Fetch with nothing held.
		push_fetch();
		// A bare CR LF is too short and is dropped.
		push_at(CHAR_CR, 16'd2);
		push_at(CHAR_LF, 16'd3);
		// Shortest line that is kept, with no known command.
		push_at("Z", 16'd4);
		push_at(CHAR_CR, 16'd5);
		push_at(CHAR_LF, 16'd6);
		push_fetch();
		// A gap one tick over the limit restarts the line after the X; the
		// final LF comes exactly at the limit.
		push_at("X", 16'd7);
		push_at("S", 16'd10);
		push_at("E", 16'd11);
		push_at("N", 16'd12);
		push_at("D", 16'd13);
		push_at(CHAR_CR, 16'd14);
		push_at(CHAR_LF, 16'd16);
		push_fetch();
		play_items(0);
		drain_outputs();

		// Random phases over gap settings, extremes included, and the four
		// kinds of handshake pressure.
		run_phase(16'hffff, 0, 0);
		run_phase(16'h0000, 54, 0);
		run_phase(16'($urandom_range(3, 40)), 0, 54);
		run_phase(16'h0001, 9, 9);
		run_phase(16'($urandom), 54, 0);
		run_phase(16'hfffe, 0, 54);
		run_phase(GAP_TICKS_RESET, 9, 9);
		run_phase(16'h0003, 0, 0);

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.mismatches == 0)
			$display("serial_command_line_framer: match");
		else
			$display("serial_command_line_framer: mismatch");
		$finish;
	end

endmodule
